/* hw/rtl/bitmap_frame_allocator_assert.svh */
// ----------------------------------------------------------------------------
// Bitmap frame allocator assertion macros
// Shorthand for clocked assertions that are disabled while reset is active.
// ----------------------------------------------------------------------------
`ifndef BITMAP_FRAME_ALLOCATOR_ASSERT_SVH
`define BITMAP_FRAME_ALLOCATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BFA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BFA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/bfa_pkg.sv */
// ----------------------------------------------------------------------------
// Bitmap frame allocator package
// Transaction types, codes and fixed widths shared by the allocator files.
// ----------------------------------------------------------------------------
package bfa_pkg;

	localparam int BASE_W   = 20;
	localparam int COUNT_W  = 11;
	localparam int FRAME_W  = 21;
	// Wide enough for first + count and for base + pool size.
	localparam int CHK_W    = 21;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_MARK  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_NOFREE = 2'd1,
		ST_RANGE  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		REG_BASE_FRAME    = 2'd0,
		REG_NUM_FRAMES    = 2'd1,
		REG_RESERVE_FIRST = 2'd2
	} reg_idx_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_MCHK1,
		S_MCHK2,
		S_SCAN,
		S_DONE
	} state_t;

	typedef struct packed {
		op_t                op;
		logic [BASE_W-1:0]  mark_first;
		logic [COUNT_W-1:0] mark_count;
	} req_t;

	typedef struct packed {
		logic [FRAME_W-1:0] frame;
		status_t            status;
	} rsp_t;

endpackage

/* hw/rtl/bfa_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bfa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* hw/rtl/bfa_word_unit.sv */
// ----------------------------------------------------------------------------
// Map word unit
// Builds the index window mask for one map word and either finds its lowest
// free bit (allocate) or sets every bit of the window (mark).
// ----------------------------------------------------------------------------
module bfa_word_unit #(
	parameter int WORD_BITS = 32,
	parameter int IDX_W     = 11,
	parameter int PW        = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1
) (
	input  logic                 mark,
	input  logic [WORD_BITS-1:0] rd_word,
	input  logic [IDX_W-1:0]     lo,
	input  logic [IDX_W-1:0]     hi,
	input  logic [IDX_W-1:0]     wbase,
	output logic                 found,
	output logic [PW-1:0]        pos,
	output logic [WORD_BITS-1:0] wr_word
);

	logic signed [IDX_W:0]  dlo;
	logic signed [IDX_W:0]  dhi;
	logic [WORD_BITS-1:0]   mask;
	logic [WORD_BITS-1:0]   free;
	logic [WORD_BITS-1:0]   lowest;

	// Window bounds relative to the first index held in this word.
	assign dlo = $signed({1'b0, lo}) - $signed({1'b0, wbase});
	assign dhi = $signed({1'b0, hi}) - $signed({1'b0, wbase});

	always_comb begin
		for (int b = 0; b < WORD_BITS; b++) begin
			mask[b] = ($signed((IDX_W+1)'(b)) >= dlo) && ($signed((IDX_W+1)'(b)) < dhi);
		end
	end

	assign free   = ~rd_word & mask;
	assign found  = |free;
	assign lowest = free & (~free + {{(WORD_BITS-1){1'b0}}, 1'b1});

	always_comb begin
		pos = '0;
		for (int b = WORD_BITS - 1; b >= 0; b--) begin
			if (free[b]) begin
				pos = PW'(b);
			end
		end
	end

	assign wr_word = mark ? (rd_word | mask) : (rd_word | lowest);

endmodule

/* hw/rtl/bitmap_frame_allocator.sv */
// ----------------------------------------------------------------------------
// Bitmap frame allocator
// First-fit allocator over a used-bit map of a pool of physical frames.
// ----------------------------------------------------------------------------
// The used map sits in a RAM of ceil(MAX_FRAMES / WORD_BITS) words that is
// read and written one word per cycle through a single word unit. After reset
// a clearing pass writes zeros to every map word; no request is taken
// meanwhile, while configuration writes are. An allocate scans the map words
// from word 0 up to the word that holds the first free frame, or to the end
// of the pool if none is free, then hands the result off. A mark passes the
// range-check states S_MCHK1 and S_MCHK2 and, unless the range is out of
// bounds, scans every word from word 0 to the last word of the range. The
// block handles one request at a time; a finished response waits in an
// output register so the next request can be accepted while it is stalled.
module bitmap_frame_allocator #(
	parameter int MAX_FRAMES = 1024,
	parameter int WORD_BITS  = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [1:0]    cfg_index,
	input  logic [19:0]   cfg_data,
	input  logic          req_valid,
	output logic          req_stall,
	input  bfa_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output bfa_pkg::rsp_t rsp
);

	import bfa_pkg::*;

	localparam int MAP_WORDS = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
	localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int XW        = $clog2(MAP_WORDS * WORD_BITS + 1);
	localparam int PW        = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;

	state_t state_q, state_d;

	logic [BASE_W-1:0]    base_q;
	logic [COUNT_W-1:0]   nf_q;
	logic                 rsv_q;
	logic [AW-1:0]        clr_q;
	logic                 rsp_valid_q;
	rsp_t                 rsp_q;

	op_t                  op_q;
	logic [BASE_W-1:0]    first_q;
	logic [COUNT_W-1:0]   count_q;
	logic [XW-1:0]        lo_q;
	logic [XW-1:0]        hi_q;
	logic [XW-1:0]        wbase_q;
	logic [AW-1:0]        w_q;
	logic [FRAME_W-1:0]   fb_q;
	logic [CHK_W-1:0]     end_q;
	logic [CHK_W-1:0]     lim_q;
	logic                 below_q;
	rsp_t                 res_q;

	logic [XW-1:0]        pool_n;
	logic [XW-1:0]        wbase_nxt;
	logic                 req_acc;
	logic                 rsp_load;
	logic                 range_bad;

	logic                 ram_we;
	logic [AW-1:0]        ram_waddr;
	logic [WORD_BITS-1:0] ram_wdata;
	logic [AW-1:0]        ram_raddr;
	logic [WORD_BITS-1:0] ram_rdata;

	logic                 u_found;
	logic [PW-1:0]        u_pos;
	logic [WORD_BITS-1:0] u_word;

	// A pool size above the map capacity is clipped to the capacity.
	always_comb begin
		if (32'(nf_q) > MAX_FRAMES) begin
			pool_n = XW'(MAX_FRAMES);
		end else begin
			pool_n = XW'(nf_q);
		end
	end

	assign req_acc   = req_valid && !req_stall;
	assign rsp_load  = (state_q == S_DONE) && (!rsp_valid_q || !rsp_stall);
	assign wbase_nxt = wbase_q + XW'(WORD_BITS);
	assign range_bad = below_q || (end_q > lim_q);

	bfa_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(MAP_WORDS),
		.AW   (AW)
	) u_map (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	bfa_word_unit #(
		.WORD_BITS(WORD_BITS),
		.IDX_W    (XW),
		.PW       (PW)
	) u_unit (
		.mark   (op_q == OP_MARK),
		.rd_word(ram_rdata),
		.lo     (lo_q),
		.hi     (hi_q),
		.wbase  (wbase_q),
		.found  (u_found),
		.pos    (u_pos),
		.wr_word(u_word)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (clr_q == AW'(MAP_WORDS - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_acc) begin
					state_d = (req.op == OP_MARK) ? S_MCHK1 : S_SCAN;
				end
			end
			S_MCHK1: state_d = S_MCHK2;
			S_MCHK2: state_d = range_bad ? S_DONE : S_SCAN;
			S_SCAN: begin
				if ((op_q == OP_ALLOC && u_found) || !(wbase_nxt < hi_q)) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (rsp_load) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_CLEAR;
		endcase
	end

	always_comb begin
		req_stall = 1'b1;
		ram_we    = 1'b0;
		ram_waddr = w_q;
		ram_wdata = u_word;
		ram_raddr = '0;
		unique case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			S_IDLE: req_stall = 1'b0;
			S_SCAN: begin
				// Write back this word while the next one is fetched.
				ram_we    = 1'b1;
				ram_raddr = w_q + AW'(1);
			end
			S_MCHK1, S_MCHK2, S_DONE: begin
				req_stall = 1'b1;
			end
			default: req_stall = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
			base_q      <= '0;
			nf_q        <= COUNT_W'(1024);
			rsv_q       <= 1'b1;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_BASE_FRAME:    base_q <= cfg_data;
					REG_NUM_FRAMES:    nf_q   <= cfg_data[COUNT_W-1:0];
					REG_RESERVE_FIRST: rsv_q  <= cfg_data[0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q <= res_q;
		end
		unique case (state_q)
			S_IDLE: begin
				if (req_acc) begin
					op_q    <= req.op;
					first_q <= req.mark_first;
					count_q <= req.mark_count;
					wbase_q <= '0;
					w_q     <= '0;
					fb_q    <= FRAME_W'(base_q);
					// An allocate searches the window from the first usable index
					// up to the pool size.
					lo_q    <= rsv_q ? XW'(1) : '0;
					hi_q    <= pool_n;
				end
			end
			S_MCHK1: begin
				below_q <= first_q < base_q;
				end_q   <= CHK_W'(first_q) + CHK_W'(count_q);
				lim_q   <= CHK_W'(base_q) + CHK_W'(pool_n);
				lo_q    <= XW'(first_q - base_q);
			end
			S_MCHK2: begin
				hi_q <= lo_q + XW'(count_q);
				if (range_bad) begin
					res_q.frame  <= '0;
					res_q.status <= ST_RANGE;
				end
			end
			S_SCAN: begin
				wbase_q <= wbase_nxt;
				w_q     <= w_q + AW'(1);
				fb_q    <= fb_q + FRAME_W'(WORD_BITS);
				if (op_q == OP_ALLOC && u_found) begin
					res_q.frame  <= fb_q + FRAME_W'(u_pos);
					res_q.status <= ST_OK;
				end else begin
					res_q.frame  <= '0;
					res_q.status <= (op_q == OP_ALLOC) ? ST_NOFREE : ST_OK;
				end
			end
			S_CLEAR, S_DONE: begin
				res_q <= res_q;
			end
			default: res_q <= res_q;
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

/* hw/rtl/bfa_chk.sv */
// ----------------------------------------------------------------------------
// Bitmap frame allocator checker
// Port-level assertions on the allocator, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "bitmap_frame_allocator_assert.svh"

module bfa_chk (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_stall,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input bfa_pkg::rsp_t rsp
);

	import bfa_pkg::*;

	// A stalled response stays offered and unchanged.
	`BFA_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "response changed while stalled")

	// Every response whose status is not ok carries frame zero.
	`BFA_ASSERT_NOW(a_fail_zero, rsp_valid && rsp.status != ST_OK, rsp.frame == '0, "failed response carries a frame")

	// The allocator works on one transaction at a time.
	`BFA_ASSERT_NEXT(a_busy, req_valid && !req_stall, req_stall, "request taken while busy")

endmodule

bind bitmap_frame_allocator bfa_chk u_bfa_chk (.*);
